/* design/tbeq_pkg.sv */
package tbeq_pkg;

    localparam int TAP_COUNT    = 21;
    localparam int UNIQUE_COEFS = 11;
    localparam int COEF_BITS    = 16;
    localparam int SAMPLE_BITS  = 12;
    localparam int BAND_COUNT   = 3;
    localparam int GAIN_BITS    = 8;
    localparam int BAND_W       = 2;
    localparam int SLOT_W       = 4;
    localparam int CFG_ADDR_W   = 2;
    localparam int DAC_BITS     = 12;
    localparam int DAC_MID      = 2048;
    localparam int DAC_MAX      = (1 << DAC_BITS) - 1;
    localparam int OUT_SHIFT    = 11 + COEF_BITS - 1;

    // one cell per symmetric tap pair, the center tap alone when the count is odd
    localparam int NPAIR   = (TAP_COUNT + 1) / 2;
    localparam int PRE_W   = SAMPLE_BITS + 1;
    localparam int PROD_W  = PRE_W + COEF_BITS;
    localparam int SUM_W   = PROD_W + $clog2(NPAIR);
    localparam int GPROD_W = SUM_W + GAIN_BITS;
    localparam int ACC_W   = GPROD_W + $clog2(BAND_COUNT);
    localparam int SCL_W   = ACC_W + 3;

    localparam int IN_DATA_W  = SAMPLE_BITS + BAND_W + SLOT_W + COEF_BITS;
    localparam int IN_TDATA_W = ((IN_DATA_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DAC_BITS + 7) / 8) * 8;

    localparam logic [BAND_W-1:0] BAND_LOW  = 2'd0;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_HIGH = 2'd2;

    localparam logic MODE_SAMPLE = 1'b0;
    localparam logic MODE_COEF   = 1'b1;

    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_LOW  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_MID  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_HIGH = 2'd2;

    typedef logic signed [SAMPLE_BITS-1:0] t_smp;
    typedef logic signed [COEF_BITS-1:0]   t_coef;
    typedef logic signed [GAIN_BITS-1:0]   t_gain;

    typedef struct packed {
        logic                     valid;
        logic [BAND_W-1:0]        band;
        logic signed [SUM_W-1:0]  sum;
    } t_tok;

endpackage

/* design/three_band_fir_equalizer_top.sv */
// A sample beat's result is loaded into the output register once the partial sums of the
// three bands have walked the row of tap-pair cells and the gain stage; no new beat is
// accepted until then, and the load waits while the output register is full and not taken.
// A coefficient beat writes a coefficient register and gives no result.
// Reset (synchronous, active low) clears the delay line, coefficients and gains.
module three_band_fir_equalizer_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // sample_raw, band_select, coef_slot, coef_value, zero fill
    input  logic [tbeq_pkg::IN_TDATA_W-1:0]     i_s_axis_tdata,
    // mode
    input  logic                                i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // dac_value, zero fill
    output logic [tbeq_pkg::OUT_TDATA_W-1:0]    o_m_axis_tdata,
    // clipped
    output logic                                o_m_axis_tuser,
    input  logic                                i_cfg_we,
    input  logic [tbeq_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [tbeq_pkg::GAIN_BITS-1:0]      i_cfg_wdata
);
    import tbeq_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_HOLD = 2'd3;

    localparam int SLOT_LO = SAMPLE_BITS + BAND_W;
    localparam int COEF_LO = SLOT_LO + SLOT_W;

    logic [1:0]          r_state;
    logic [1:0]          n_state;
    logic [BAND_W-1:0]   r_cnt;
    logic [BAND_W-1:0]   n_cnt;
    t_gain               r_gain_low;
    t_gain               r_gain_mid;
    t_gain               r_gain_high;
    logic                r_out_valid;
    logic [DAC_BITS-1:0] r_out_dac;
    logic                r_out_clip;

    logic                w_accept;
    logic                w_shift;
    logic                w_coef_wr;
    logic                w_out_free;
    logic                w_load;
    logic [SAMPLE_BITS-1:0] w_raw;
    logic [BAND_W-1:0]   w_band;
    logic [SLOT_W-1:0]   w_slot;
    t_coef               w_coef;
    t_smp                w_centered;
    t_smp                w_front [NPAIR];
    t_smp                w_fold  [NPAIR];
    t_tok                w_tok   [NPAIR+1];
    logic                w_we    [NPAIR];
    logic                w_done;
    logic [DAC_BITS-1:0] w_dac;
    logic                w_clip;

    assign w_raw  = i_s_axis_tdata[SAMPLE_BITS-1:0];
    assign w_band = i_s_axis_tdata[SLOT_LO-1:SAMPLE_BITS];
    assign w_slot = i_s_axis_tdata[COEF_LO-1:SLOT_LO];
    assign w_coef = i_s_axis_tdata[COEF_LO+COEF_BITS-1:COEF_LO];

    // drop the mid-scale offset: flip the top bit
    assign w_centered = {~w_raw[SAMPLE_BITS-1], w_raw[SAMPLE_BITS-2:0]};

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_shift   = w_accept && (i_s_axis_tuser == MODE_SAMPLE);
    assign w_coef_wr = w_accept && (i_s_axis_tuser == MODE_COEF)
                       && (w_band < BAND_W'(BAND_COUNT));

    assign w_tok[0].valid = (r_state == ST_RUN);
    assign w_tok[0].band  = r_cnt;
    assign w_tok[0].sum   = '0;

    for (genvar j = 0; j < NPAIR; j++) begin : g_cell
        if (j < UNIQUE_COEFS) begin : g_we
            assign w_we[j] = w_coef_wr && (32'(w_slot) == j);
        end else begin : g_no_we
            assign w_we[j] = 1'b0;
        end

        tbeq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_single     ((TAP_COUNT % 2 == 1) && (j == NPAIR - 1)),
            .i_shift      (w_shift),
            .i_front_in   ((j == 0) ? w_centered : w_front[(j == 0) ? 0 : j - 1]),
            .i_back_in    ((j == NPAIR - 1) ? w_front[j]
                                            : w_fold[(j == NPAIR - 1) ? j : j + 1]),
            .o_front      (w_front[j]),
            .o_fold       (w_fold[j]),
            .i_coef_we    (w_we[j]),
            .i_coef_band  (w_band),
            .i_coef_value (w_coef),
            .i_tok        (w_tok[j]),
            .o_tok        (w_tok[j+1])
        );
    end

    tbeq_tail u_tail (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (w_shift),
        .i_tok       (w_tok[NPAIR]),
        .i_gain_low  (r_gain_low),
        .i_gain_mid  (r_gain_mid),
        .i_gain_high (r_gain_high),
        .o_done      (w_done),
        .o_dac       (w_dac),
        .o_clip      (w_clip)
    );

    assign w_out_free = !r_out_valid || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        w_load  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                n_cnt = '0;
                if (w_shift) begin
                    n_state = ST_RUN;
                end
            end
            ST_RUN: begin
                // one token per band enters the first cell
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == BAND_W'(BAND_COUNT - 1)) begin
                    n_state = ST_WAIT;
                    n_cnt   = '0;
                end
            end
            ST_WAIT: begin
                if (w_done) begin
                    if (w_out_free) begin
                        w_load  = 1'b1;
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_HOLD;
                    end
                end
            end
            ST_HOLD: begin
                if (w_out_free) begin
                    w_load  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_gain_low  <= '0;
            r_gain_mid  <= '0;
            r_gain_high <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    CFG_GAIN_LOW:  r_gain_low  <= i_cfg_wdata;
                    CFG_GAIN_MID:  r_gain_mid  <= i_cfg_wdata;
                    CFG_GAIN_HIGH: r_gain_high <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
        if (w_load) begin
            r_out_dac  <= w_dac;
            r_out_clip <= w_clip;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {(OUT_TDATA_W - DAC_BITS)'(0), r_out_dac};
    assign o_m_axis_tuser  = r_out_clip;

endmodule

/* design/tbeq_cell.sv */
module tbeq_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_single,
    input  logic                           i_shift,
    input  tbeq_pkg::t_smp                 i_front_in,
    input  tbeq_pkg::t_smp                 i_back_in,
    output tbeq_pkg::t_smp                 o_front,
    output tbeq_pkg::t_smp                 o_fold,
    input  logic                           i_coef_we,
    input  logic [tbeq_pkg::BAND_W-1:0]    i_coef_band,
    input  tbeq_pkg::t_coef                i_coef_value,
    input  tbeq_pkg::t_tok                 i_tok,
    output tbeq_pkg::t_tok                 o_tok
);
    import tbeq_pkg::*;

    t_smp  r_front;
    t_smp  r_back;
    t_coef r_coef [BAND_COUNT];
    t_tok  r_tok;
    t_tok  n_tok;

    logic signed [PRE_W-1:0]  w_pre;
    logic signed [PROD_W-1:0] w_prod;
    t_coef                    w_coef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            for (int b = 0; b < BAND_COUNT; b++) begin
                r_coef[b] <= '0;
            end
        end else begin
            if (i_shift) begin
                r_front <= i_front_in;
                r_back  <= i_back_in;
            end
            if (i_coef_we) begin
                r_coef[i_coef_band] <= i_coef_value;
            end
        end
    end

    always_comb begin
        // fold the pair first, the center tap stands alone
        if (i_single) begin
            w_pre = PRE_W'(r_front);
        end else begin
            w_pre = PRE_W'(r_front) + PRE_W'(r_back);
        end
        if (i_tok.band < BAND_W'(BAND_COUNT)) begin
            w_coef = r_coef[i_tok.band];
        end else begin
            w_coef = '0;
        end
        w_prod      = w_pre * w_coef;
        n_tok.valid = i_tok.valid;
        n_tok.band  = i_tok.band;
        n_tok.sum   = i_tok.sum + SUM_W'(w_prod);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.band <= n_tok.band;
        r_tok.sum  <= n_tok.sum;
    end

    assign o_front = r_front;
    assign o_fold  = i_single ? r_front : r_back;
    assign o_tok   = r_tok;

endmodule

/* design/tbeq_tail.sv */
module tbeq_tail (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  tbeq_pkg::t_tok                i_tok,
    input  tbeq_pkg::t_gain               i_gain_low,
    input  tbeq_pkg::t_gain               i_gain_mid,
    input  tbeq_pkg::t_gain               i_gain_high,
    output logic                          o_done,
    output logic [tbeq_pkg::DAC_BITS-1:0] o_dac,
    output logic                          o_clip
);
    import tbeq_pkg::*;

    logic signed [GPROD_W-1:0] r_gp;
    logic                      r_gp_valid;
    logic                      r_gp_last;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_done;

    t_gain                     w_gain;
    logic signed [SCL_W-1:0]   w_scl;
    logic signed [SCL_W-1:0]   w_code;

    always_comb begin
        unique case (i_tok.band)
            BAND_LOW:  w_gain = i_gain_low;
            BAND_MID:  w_gain = i_gain_mid;
            BAND_HIGH: w_gain = i_gain_high;
            default:   w_gain = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gp_valid <= 1'b0;
            r_gp_last  <= 1'b0;
            r_done     <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_gp_valid <= i_tok.valid;
            r_gp_last  <= i_tok.valid && (i_tok.band == BAND_W'(BAND_COUNT - 1));
            r_done     <= r_gp_valid && r_gp_last;
            if (i_clear) begin
                r_acc <= '0;
            end else if (r_gp_valid) begin
                r_acc <= r_acc + ACC_W'(r_gp);
            end
        end
        r_gp <= GPROD_W'(i_tok.sum) * GPROD_W'(w_gain);
    end

    always_comb begin
        // times seven, floor divide, recenter
        w_scl  = (SCL_W'(r_acc) <<< 3) - SCL_W'(r_acc);
        w_code = (w_scl >>> OUT_SHIFT) + SCL_W'(DAC_MID);
        if (w_code < 0) begin
            o_dac  = '0;
            o_clip = 1'b1;
        end else if (w_code > SCL_W'(DAC_MAX)) begin
            o_dac  = DAC_BITS'(DAC_MAX);
            o_clip = 1'b1;
        end else begin
            o_dac  = w_code[DAC_BITS-1:0];
            o_clip = 1'b0;
        end
    end

    assign o_done = r_done;

endmodule
